/* design/dsbs_pkg.sv */
// ----------------------------------------------------------------------------
// dsbs_pkg
// Shared types and codes for the sorted table with binary search.
// ----------------------------------------------------------------------------
package dsbs_pkg;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned POS_W    = 10;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned STATUS_W = 2;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DUP   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_ORDER = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_EMIT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic in_ready;
    logic take;
    logic probe;
    logic emit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic search_go;
    logic probe_done;
    logic out_free;
    logic tbl_empty;
  } dp_sts_t;

endpackage

/* design/dsbs_if.sv */
// ----------------------------------------------------------------------------
// dsbs_in_if / dsbs_out_if
// Valid/ready channels for items and results.
// ----------------------------------------------------------------------------
interface dsbs_in_if;
  import dsbs_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

interface dsbs_out_if;
  import dsbs_pkg::*;

  logic                valid;
  logic                ready;
  logic                found;
  logic [POS_W-1:0]    position;
  logic [COUNT_W-1:0]  stored_count;
  logic [STATUS_W-1:0] status;

  modport source (output valid, found, position, stored_count, status, input ready);
  modport sink   (input valid, found, position, stored_count, status, output ready);
endinterface

/* design/dsbs_ram.sv */
// ----------------------------------------------------------------------------
// dsbs_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dsbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* design/dsbs_ctrl.sv */
// ----------------------------------------------------------------------------
// dsbs_ctrl
// Sequencer: take an item, step the search one probe per cycle, hand off result.
// ----------------------------------------------------------------------------
module dsbs_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  dsbs_pkg::dp_sts_t     sts_i,
  output dsbs_pkg::ctrl_cmd_t   cmd_o
);
  import dsbs_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.search_go ? S_CHECK : S_EMIT;
        end
      end
      S_CHECK: begin
        if (sts_i.probe_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.take     = in_valid_i;
      end
      S_CHECK: begin
        cmd_o.probe = 1'b1;
      end
      S_EMIT: begin
        cmd_o.emit = sts_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* design/dsbs_dp.sv */
// ----------------------------------------------------------------------------
// dsbs_dp
// Table store, count and last value, search bounds and the output register.
// ----------------------------------------------------------------------------
module dsbs_dp #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  dsbs_pkg::ctrl_cmd_t                    cmd_i,
  output dsbs_pkg::dp_sts_t                      sts_o,
  input  logic [dsbs_pkg::KIND_W-1:0]            in_kind_i,
  input  logic signed [dsbs_pkg::VALUE_W-1:0]    in_value_i,
  input  logic                                   out_ready_i,
  output logic                                   out_valid_o,
  output logic                                   out_found_o,
  output logic [dsbs_pkg::POS_W-1:0]             out_position_o,
  output logic [dsbs_pkg::COUNT_W-1:0]           out_stored_count_o,
  output logic [dsbs_pkg::STATUS_W-1:0]          out_status_o
);
  import dsbs_pkg::*;

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]          count_q, count_d;
  logic signed [VALUE_W-1:0] last_q, last_d;
  logic signed [VALUE_W-1:0] key_q, key_d;
  logic [IDX_W-1:0]          lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic                      found_q, found_d;
  logic [IDX_W-1:0]          pos_q, pos_d;
  logic [STATUS_W-1:0]       status_q, status_d;

  logic                      out_valid_q, out_valid_d;
  logic                      out_found_q, out_found_d;
  logic [POS_W-1:0]          out_pos_q, out_pos_d;
  logic [COUNT_W-1:0]        out_cnt_q, out_cnt_d;
  logic [STATUS_W-1:0]       out_status_q, out_status_d;

  logic                      cnt_zero, cnt_full, is_dup, is_order;
  logic [IDX_W-1:0]          hi_init, lo_nx, hi_nx, mid_nx, raddr;
  logic [IDX_W:0]            bound_sum;
  logic                      ram_we;
  logic signed [VALUE_W-1:0] probe_val;
  logic [VALUE_W-1:0]        rdata;
  logic                      hit, less, range_last;

  assign probe_val = $signed(rdata);

  assign cnt_zero = (count_q == '0);
  assign cnt_full = (count_q == CNT_W'(DEPTH));
  assign is_dup   = !cnt_zero && (in_value_i == last_q);
  assign is_order = !cnt_zero && (in_value_i < last_q);
  assign hi_init  = IDX_W'(count_q - CNT_W'(1));

  assign hit        = (probe_val == key_q);
  assign less       = (probe_val < key_q);
  // search range is used up once the probe sat on the bound that moves past it
  assign range_last = less ? (mid_q == hi_q) : (mid_q == lo_q);
  assign lo_nx      = less ? IDX_W'(mid_q + IDX_W'(1)) : lo_q;
  assign hi_nx      = less ? hi_q : IDX_W'(mid_q - IDX_W'(1));
  assign bound_sum  = {1'b0, lo_nx} + {1'b0, hi_nx};
  assign mid_nx     = bound_sum[IDX_W:1];

  assign raddr  = cmd_i.take ? (hi_init >> 1) : mid_nx;
  assign ram_we = cmd_i.take && (in_kind_i == KIND_LOAD)
                  && !is_dup && !is_order && !cnt_full;

  dsbs_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (in_value_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    count_d  = count_q;
    last_d   = last_q;
    key_d    = key_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    mid_d    = mid_q;
    found_d  = found_q;
    pos_d    = pos_q;
    status_d = status_q;
    if (cmd_i.take) begin
      found_d  = 1'b0;
      pos_d    = '0;
      status_d = STATUS_OK;
      case (in_kind_i)
        KIND_CLEAR: begin
          count_d = '0;
          last_d  = '0;
        end
        KIND_LOAD: begin
          if (is_dup) begin
            status_d = STATUS_DUP;
          end else if (is_order) begin
            status_d = STATUS_ORDER;
          end else if (cnt_full) begin
            status_d = STATUS_FULL;
          end else begin
            count_d = count_q + CNT_W'(1);
            last_d  = in_value_i;
          end
        end
        KIND_SEARCH: begin
          key_d = in_value_i;
          lo_d  = '0;
          hi_d  = hi_init;
          mid_d = hi_init >> 1;
        end
        default: ;
      endcase
    end else if (cmd_i.probe) begin
      if (hit) begin
        found_d = 1'b1;
        pos_d   = mid_q;
      end else begin
        lo_d  = lo_nx;
        hi_d  = hi_nx;
        mid_d = mid_nx;
      end
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_found_d  = out_found_q;
    out_pos_d    = out_pos_q;
    out_cnt_d    = out_cnt_q;
    out_status_d = out_status_q;
    if (cmd_i.emit) begin
      out_valid_d  = 1'b1;
      out_found_d  = found_q;
      out_pos_d    = POS_W'(pos_q);
      out_cnt_d    = COUNT_W'(count_q);
      out_status_d = status_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    mid_q        <= mid_d;
    found_q      <= found_d;
    pos_q        <= pos_d;
    status_q     <= status_d;
    out_found_q  <= out_found_d;
    out_pos_q    <= out_pos_d;
    out_cnt_q    <= out_cnt_d;
    out_status_q <= out_status_d;
  end

  assign sts_o.search_go  = (in_kind_i == KIND_SEARCH) && !cnt_zero;
  assign sts_o.probe_done = hit || range_last;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.tbl_empty  = cnt_zero;

  assign out_valid_o        = out_valid_q;
  assign out_found_o        = out_found_q;
  assign out_position_o     = out_pos_q;
  assign out_stored_count_o = out_cnt_q;
  assign out_status_o       = out_status_q;

endmodule

/* design/dedup_sorted_table_binary_search.sv */
// ----------------------------------------------------------------------------
// dedup_sorted_table_binary_search
// Sorted table of distinct signed words with load, clear and binary search.
// ----------------------------------------------------------------------------
// Each transaction on in_i gives exactly one transaction on out_o. Clear, load
// and unused kinds pass from acceptance through S_EMIT into the result
// register. A search of a non-empty table first makes n probes in S_CHECK,
// where n is at most floor(log2(count)) + 1; the single registered read port of
// the table RAM serves one midpoint probe per cycle. A search of an empty table
// goes straight to S_EMIT. A new item is accepted once the previous one has
// moved into the output register, even while that result is still waiting on
// out_o. The table needs no clearing pass after reset: only entries below the
// count are ever probed.
module dedup_sorted_table_binary_search #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  dsbs_in_if.sink          in_i,
  dsbs_out_if.source       out_o
);
  import dsbs_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  dsbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dsbs_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .in_kind_i          (in_i.kind),
    .in_value_i         (in_i.value),
    .out_ready_i        (out_o.ready),
    .out_valid_o        (out_o.valid),
    .out_found_o        (out_o.found),
    .out_position_o     (out_o.position),
    .out_stored_count_o (out_o.stored_count),
    .out_status_o       (out_o.status)
  );

  assign in_i.ready = cmd.in_ready;

  // a clear transaction leaves the table empty
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && (in_i.kind == KIND_CLEAR) |=> sts.tbl_empty)
    else $error("table not empty after clear");

  // no new item while a search is probing
  a_no_take_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.probe |-> !in_i.ready && !cmd.emit)
    else $error("input ready during search");

  // a hit always reports ok status
  a_hit_status_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.found |-> out_o.status == STATUS_OK)
    else $error("hit with non-ok status");

endmodule
